### hdl/fbc_pkg.sv
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the ftyp brand classifier.
// Holds the four-character codes, the verdict codes and the brand match flags.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int unsigned DATA_W = 8;
    localparam int unsigned POS_W  = 64;
    localparam int unsigned WORD_W = 32;

    localparam logic [WORD_W-1:0] FOURCC_FTYP = 32'h66747970;
    localparam logic [WORD_W-1:0] FOURCC_MIF1 = 32'h6d696631;
    localparam logic [WORD_W-1:0] FOURCC_HEIC = 32'h68656963;
    localparam logic [WORD_W-1:0] FOURCC_MSF1 = 32'h6d736631;
    localparam logic [WORD_W-1:0] FOURCC_HEVC = 32'h68657663;
    localparam logic [WORD_W-1:0] FOURCC_AVIF = 32'h61766966;
    localparam logic [WORD_W-1:0] FOURCC_AVIS = 32'h61766973;

    localparam logic [POS_W-1:0] POS_MAX       = '1;
    localparam logic [POS_W-1:0] BASE_OFFSET   = 64'd8;
    localparam logic [POS_W-1:0] EXT_OFFSET    = 64'd16;
    localparam logic [POS_W-1:0] MIN_SIZE      = 64'd8;
    localparam logic [POS_W-1:0] EXT_MIN_SIZE  = 64'd16;
    localparam logic [POS_W-1:0] EXT_SIZE_CODE = 64'd1;

    typedef enum logic [1:0] {
        VERDICT_NONE = 2'd0,
        VERDICT_HEIF = 2'd1,
        VERDICT_AVIF = 2'd2
    } verdict_t;

    typedef struct packed {
        logic is_avif;
        logic is_heif;
    } brand_match_t;

endpackage

### hdl/fbc_brand_match.sv
// ----------------------------------------------------------------------------
// fbc_brand_match: brand word classifier.
// Compares one four-character brand against the AVIF and HEIF brand sets.
// ----------------------------------------------------------------------------
module fbc_brand_match (
    input  logic [31:0]          brand,
    output fbc_pkg::brand_match_t match
);
    import fbc_pkg::*;

    always_comb begin
        match.is_avif = (brand == FOURCC_AVIF) || (brand == FOURCC_AVIS);
        match.is_heif = (brand == FOURCC_MIF1) || (brand == FOURCC_HEIC) ||
                        (brand == FOURCC_MSF1) || (brand == FOURCC_HEVC);
    end

endmodule

### hdl/ftyp_brand_classifier.sv
// ----------------------------------------------------------------------------
// ftyp_brand_classifier: HEIF and AVIF sniffer for the leading ftyp box.
// Parses the box header byte by byte and gives one verdict per file.
// ----------------------------------------------------------------------------
// The input stream carries the leading bytes of a file, one byte per beat,
// with s_tlast set on the last byte that is available. Each beat updates the
// parse state when accepted; a new byte is taken each cycle unless stalled.
// The beat with s_tlast produces one result beat, which appears on m_tdata
// in the next cycle (verdict in the two low bits: 0 not recognized, 1 HEIF
// family, 2 AVIF). Beats without s_tlast produce no result.
// After the final beat the parse state returns to its reset value, so the
// next beat starts a new file.
// The result sits in a single output register. While it waits for the
// receiver, s_tready stays high if m_tready is high in the same cycle, so a
// stream flows at one byte per cycle; if the receiver stalls with a result
// pending, s_tready drops until that result is taken.
// Reset (aresetn low, synchronous) clears the parse state and drops m_tvalid.
// ----------------------------------------------------------------------------
module ftyp_brand_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] verdict, [7:2] zero
);
    import fbc_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  size_reg, size_next;
    logic [POS_W-1:0]  box_reg, box_next;
    logic              ext_reg, ext_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic              heif_reg, heif_next;
    logic              avif_reg, avif_next;
    logic              rej_reg, rej_next;
    logic              m_tvalid_reg, m_tvalid_next;
    verdict_t          verdict_reg, verdict_next;

    logic [WORD_W-1:0] shifted_word;
    logic [POS_W-1:0]  offset;
    logic [POS_W-1:0]  need;
    brand_match_t      match;
    logic              s_fire;

    assign shifted_word = {word_reg[WORD_W-9:0], s_tdata};

    fbc_brand_match u_match (
        .brand (shifted_word),
        .match (match)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, verdict_reg};
    assign offset   = ext_reg ? EXT_OFFSET : BASE_OFFSET;

    always_comb begin
        pos_next      = pos_reg;
        size_next     = size_reg;
        box_next      = box_reg;
        ext_next      = ext_reg;
        word_next     = word_reg;
        heif_next     = heif_reg;
        avif_next     = avif_reg;
        rej_next      = rej_reg;
        if (pos_reg != POS_MAX) begin
            pos_next  = pos_reg + 64'd1;
            word_next = shifted_word;
            if (pos_reg < 64'd4) begin
                size_next = {size_reg[POS_W-9:0], s_tdata};
                if (pos_reg == 64'd3) begin
                    box_next = size_next;
                    if (size_next == EXT_SIZE_CODE) begin
                        ext_next = 1'b1;
                    end else if (size_next < MIN_SIZE) begin
                        rej_next = 1'b1;
                    end
                end
            end else if (pos_reg < 64'd8) begin
                if (pos_reg == 64'd7 && shifted_word != FOURCC_FTYP) begin
                    rej_next = 1'b1;
                end
            end else if (ext_reg && pos_reg < 64'd16) begin
                size_next = {size_reg[POS_W-9:0], s_tdata};
                if (pos_reg == 64'd15) begin
                    box_next = size_next;
                    if (size_next < EXT_MIN_SIZE) begin
                        rej_next = 1'b1;
                    end
                end
            end else if (pos_reg[1:0] == 2'b11) begin
                // The major brand always counts; compatible brands only inside the box.
                if (pos_reg == offset + 64'd3 ||
                    (pos_reg >= offset + 64'd8 && pos_reg < box_reg)) begin
                    if (match.is_avif) begin
                        avif_next = 1'b1;
                    end else if (match.is_heif) begin
                        heif_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        need = (ext_next ? EXT_OFFSET : BASE_OFFSET) + 64'd8;
        if (rej_next || pos_next < need || box_next < need) begin
            verdict_next = VERDICT_NONE;
        end else if (avif_next) begin
            verdict_next = VERDICT_AVIF;
        end else if (heif_next) begin
            verdict_next = VERDICT_HEIF;
        end else begin
            verdict_next = VERDICT_NONE;
        end
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (s_fire && s_tlast) begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            size_reg     <= '0;
            box_reg      <= '0;
            ext_reg      <= 1'b0;
            word_reg     <= '0;
            heif_reg     <= 1'b0;
            avif_reg     <= 1'b0;
            rej_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_fire) begin
                if (s_tlast) begin
                    pos_reg  <= '0;
                    size_reg <= '0;
                    box_reg  <= '0;
                    ext_reg  <= 1'b0;
                    word_reg <= '0;
                    heif_reg <= 1'b0;
                    avif_reg <= 1'b0;
                    rej_reg  <= 1'b0;
                end else begin
                    pos_reg  <= pos_next;
                    size_reg <= size_next;
                    box_reg  <= box_next;
                    ext_reg  <= ext_next;
                    word_reg <= word_next;
                    heif_reg <= heif_next;
                    avif_reg <= avif_next;
                    rej_reg  <= rej_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_tlast) begin
            verdict_reg <= verdict_next;
        end
    end

endmodule

### hdl/fbc_checker.sv
// ----------------------------------------------------------------------------
// fbc_checker: port-level checks of the ftyp brand classifier.
// Watches the stream ports and flags handshake and result timing errors.
// ----------------------------------------------------------------------------
module fbc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A result beat that the receiver has not taken stays unchanged.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A final input beat yields a result beat in the next cycle.
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("final beat gave no result");

    // A non-final beat with the output free yields no result.
    a_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast && (!m_tvalid || m_tready) |=> !m_tvalid)
        else $error("result without a final beat");

    // No input beat is taken while a pending result is stalled.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken over a stalled result");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind ftyp_brand_classifier fbc_checker u_fbc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
